// ----- sv/lzss_pkg.sv -----
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants of the LZSS block decompressor: stream and
// result payloads, the command passed from the parser to the copy engine.
// ----------------------------------------------------------------------------
package lzss_pkg;

  // History memory size is 2**HIST_BITS bytes (8 to 16)
  localparam int HIST_BITS  = 16;
  localparam int HIST_DEPTH = 1 << HIST_BITS;

  // Command queue between parser and copy engine
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte_a;
    logic [7:0] out_byte_b;
    logic [7:0] out_byte_c;
    logic [7:0] out_byte_d;
    logic [2:0] out_count;
    logic       out_final;
  } out_t;

  typedef enum logic {
    CMD_LITERAL = 1'b0,
    CMD_COPY    = 1'b1
  } cmd_kind_t;

  // Literal: data is the byte. Copy: data is the byte count (nonzero).
  typedef struct packed {
    cmd_kind_t              kind;
    logic [7:0]             data;
    logic [HIST_BITS-1:0]   addr;
  } cmd_t;

endpackage

// ----- sv/lzss_front.sv -----
// ----------------------------------------------------------------------------
// lzss_front
// Stream parser: walks count, literal, address and length bytes of each
// block and pushes literal and copy commands into the command queue.
// ----------------------------------------------------------------------------
module lzss_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lzss_pkg::in_t       in_data,
  input  logic                cmd_full,
  input  logic                clear_busy,
  output logic                cmd_push,
  output lzss_pkg::cmd_t      cmd_wdata
);

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_FIRST   = 3'd1,
    PH_GROUP   = 3'd2,
    PH_ADDR_HI = 3'd3,
    PH_ADDR_LO = 3'd4,
    PH_LEN     = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  groups_left, groups_left_next;
  logic [1:0]  byte_in_group, byte_in_group_next;
  logic [15:0] ref_address, ref_address_next;
  logic        accept;
  logic [7:0]  b;
  logic [1:0]  big_inc;
  logic [7:0]  copy_len;

  assign in_ready = !cmd_full && !clear_busy;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.in_byte;
  assign big_inc  = byte_in_group + 2'd1;
  assign copy_len = b - 8'd1;

  // Classify the byte and work out the next parse position
  always_comb begin
    phase_next         = phase;
    groups_left_next   = groups_left;
    byte_in_group_next = byte_in_group;
    ref_address_next   = ref_address;
    cmd_push           = 1'b0;
    cmd_wdata.kind     = lzss_pkg::CMD_LITERAL;
    cmd_wdata.data     = b;
    cmd_wdata.addr     = ref_address[lzss_pkg::HIST_BITS-1:0];
    case (phase)
      PH_COUNT: begin
        groups_left_next   = (b > 8'd1) ? copy_len : 8'd0;
        byte_in_group_next = 2'd0;
        phase_next         = PH_FIRST;
      end
      PH_FIRST: begin
        cmd_push           = accept;
        byte_in_group_next = big_inc;
        if (big_inc >= 2'd2) begin
          byte_in_group_next = 2'd0;
          phase_next         = (groups_left != 8'd0) ? PH_GROUP : PH_ADDR_HI;
        end
      end
      PH_GROUP: begin
        cmd_push           = accept;
        byte_in_group_next = big_inc;
        if (big_inc >= 2'd3) begin
          byte_in_group_next = 2'd0;
          groups_left_next   = groups_left - 8'd1;
          if (groups_left == 8'd1) begin
            phase_next = PH_ADDR_HI;
          end
        end
      end
      PH_ADDR_HI: begin
        ref_address_next = {b, 8'd0};
        phase_next       = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        ref_address_next = {ref_address[15:8], b};
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        // A length byte of one copies nothing
        cmd_push       = accept && (copy_len != 8'd0);
        cmd_wdata.kind = lzss_pkg::CMD_COPY;
        cmd_wdata.data = copy_len;
        phase_next     = PH_COUNT;
      end
      default: begin
        phase_next = PH_COUNT;
      end
    endcase
    // Drop an unfinished block at the end of the stream
    if (in_data.in_last) begin
      phase_next         = PH_COUNT;
      groups_left_next   = 8'd0;
      byte_in_group_next = 2'd0;
    end
  end

  // Advance parse state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_COUNT;
      groups_left   <= 8'd0;
      byte_in_group <= 2'd0;
      ref_address   <= 16'd0;
    end else if (accept) begin
      phase         <= phase_next;
      groups_left   <= groups_left_next;
      byte_in_group <= byte_in_group_next;
      ref_address   <= ref_address_next;
    end
  end

endmodule

// ----- sv/lzss_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// lzss_cmd_fifo
// Short command queue that decouples the parser from the copy engine.
// ----------------------------------------------------------------------------
module lzss_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lzss_pkg::cmd_t      wdata,
  output logic                full,
  input  logic                pop,
  output logic                nonempty,
  output lzss_pkg::cmd_t      rdata
);

  lzss_pkg::cmd_t                    entries [lzss_pkg::CMD_DEPTH];
  logic [lzss_pkg::CMD_PTR_W-1:0]    wr_ptr;
  logic [lzss_pkg::CMD_PTR_W-1:0]    rd_ptr;
  logic [lzss_pkg::CMD_CNT_W-1:0]    count;
  logic                              do_push;
  logic                              do_pop;

  assign full     = (count == lzss_pkg::CMD_CNT_W'(lzss_pkg::CMD_DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/lzss_back.sv -----
// ----------------------------------------------------------------------------
// lzss_back
// Copy engine: owns the history memory, clears it after reset, writes
// literals, replays back-references byte by byte and packs results.
// ----------------------------------------------------------------------------
module lzss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  lzss_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                clear_busy,
  output logic                out_valid,
  input  logic                out_ready,
  output lzss_pkg::out_t      out_data
);

  localparam int HB = lzss_pkg::HIST_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_READ  = 3'd2,
    ST_DATA  = 3'd3,
    ST_EMIT  = 3'd4
  } state_t;

  logic [7:0]    hist [lzss_pkg::HIST_DEPTH];
  logic [7:0]    rd_q;

  state_t        state;
  logic [HB-1:0] clr_addr;
  logic [HB-1:0] wp;
  logic [HB-1:0] src;
  logic [7:0]    remain;
  logic [7:0]    acc [4];
  logic [2:0]    acc_cnt;

  logic          we;
  logic [HB-1:0] waddr;
  logic [7:0]    wdata;
  logic          slot_free;

  assign clear_busy = (state == ST_CLEAR);
  assign slot_free  = !out_valid || out_ready;

  // Select the memory write: clearing sweep, literal or copied byte
  always_comb begin
    we      = 1'b0;
    waddr   = wp;
    wdata   = rd_q;
    cmd_pop = 1'b0;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = 8'd0;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == lzss_pkg::CMD_LITERAL) begin
            we      = slot_free;
            wdata   = cmd.data;
            cmd_pop = slot_free;
          end else begin
            cmd_pop = 1'b1;
          end
        end
      end
      ST_DATA: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // History memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      hist[waddr] <= wdata;
    end
    rd_q <= hist[src];
  end

  // Sequence commands and hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      wp        <= '0;
      src       <= '0;
      remain    <= 8'd0;
      acc_cnt   <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {HB{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.kind == lzss_pkg::CMD_LITERAL) begin
              if (slot_free) begin
                wp                  <= wp + 1'b1;
                out_valid           <= 1'b1;
                out_data.out_byte_a <= cmd.data;
                out_data.out_byte_b <= 8'd0;
                out_data.out_byte_c <= 8'd0;
                out_data.out_byte_d <= 8'd0;
                out_data.out_count  <= 3'd1;
                out_data.out_final  <= 1'b1;
              end
            end else begin
              src     <= cmd.addr;
              remain  <= cmd.data;
              acc[0]  <= 8'd0;
              acc[1]  <= 8'd0;
              acc[2]  <= 8'd0;
              acc[3]  <= 8'd0;
              acc_cnt <= 3'd0;
              state   <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_DATA;
        end
        ST_DATA: begin
          acc[acc_cnt[1:0]] <= rd_q;
          acc_cnt           <= acc_cnt + 3'd1;
          wp                <= wp + 1'b1;
          src               <= src + 1'b1;
          remain            <= remain - 8'd1;
          if (acc_cnt == 3'd3 || remain == 8'd1) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_READ;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid           <= 1'b1;
            out_data.out_byte_a <= acc[0];
            out_data.out_byte_b <= acc[1];
            out_data.out_byte_c <= acc[2];
            out_data.out_byte_d <= acc[3];
            out_data.out_count  <= acc_cnt;
            out_data.out_final  <= (remain == 8'd0);
            acc[0]              <= 8'd0;
            acc[1]              <= 8'd0;
            acc[2]              <= 8'd0;
            acc[3]              <= 8'd0;
            acc_cnt             <= 3'd0;
            state               <= (remain == 8'd0) ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/lzss_block_decompressor.sv -----
// ----------------------------------------------------------------------------
// lzss_block_decompressor
// LZSS block decompressor: compressed bytes in, packed decompressed bytes out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one compressed stream byte
// per transaction; in_last ends the stream and drops any unfinished block.
// Output channel (out_valid/out_ready/out_data) gives up to four bytes per
// transaction with out_count valid bytes and out_final on the last result
// caused by an input byte.
// Count and address bytes give no result. A literal goes through the command
// queue and the output register; literals sustain one per cycle while the
// receiver does not stall. A back-reference runs in the copy engine byte by
// byte (memory read, then write back), with an emit step per result and a
// start step, as every copied byte must see the bytes written just before it.
// A four-entry command queue lets the parser keep taking bytes while the
// engine copies; in_ready drops when the queue is full.
// After reset the history memory is cleared, one entry a cycle, through all
// 65536 entries; in_ready stays low during this pass. When the receiver stalls, the
// output register holds its result and the engine waits, filling the queue.
// ----------------------------------------------------------------------------
module lzss_block_decompressor (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lzss_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lzss_pkg::out_t      out_data
);

  logic            cmd_push;
  lzss_pkg::cmd_t  cmd_wdata;
  logic            cmd_full;
  logic            cmd_pop;
  logic            cmd_nonempty;
  lzss_pkg::cmd_t  cmd_rdata;
  logic            clear_busy;

  // Parse the stream into commands
  lzss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cmd_full   (cmd_full),
    .clear_busy (clear_busy),
    .cmd_push   (cmd_push),
    .cmd_wdata  (cmd_wdata)
  );

  // Queue commands between parser and engine
  lzss_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .wdata    (cmd_wdata),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .nonempty (cmd_nonempty),
    .rdata    (cmd_rdata)
  );

  // Execute commands against the history memory
  lzss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_nonempty),
    .cmd        (cmd_rdata),
    .cmd_pop    (cmd_pop),
    .clear_busy (clear_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- test/tb_lzss_block_decompressor.sv -----
// ----------------------------------------------------------------------------
// tb_lzss_block_decompressor
// Self-checking bench for the LZSS block decompressor. A scoreboard keeps its
// own history memory and parser state, predicts the packed output words for
// every accepted stream byte, and compares each output transaction field by
// field. Stimulus is a short directed set of blocks followed by random blocks
// with random stalls on both channels, one long receiver hold and one drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef enum logic [2:0] {
  PH_COUNT,
  PH_FIRST,
  PH_GROUP,
  PH_ADDR_HI,
  PH_ADDR_LO,
  PH_LEN
} stream_phase_t;

class lzss_output_scoreboard;
  bit [7:0]                      hist [lzss_pkg::HIST_DEPTH];
  logic [lzss_pkg::HIST_BITS-1:0] wptr;
  stream_phase_t                 phase;
  logic [7:0]                    groups_left;
  logic [1:0]                    grp_pos;
  logic [15:0]                   ref_addr;
  lzss_pkg::out_t                pending_words [$];
  int n_bytes, n_words, n_errors, n_copies, max_copy, n_dropped;

  function new();
    foreach (hist[i]) hist[i] = 8'h00;
    wptr        = '0;
    phase       = PH_COUNT;
    groups_left = 8'd0;
    grp_pos     = 2'd0;
    ref_addr    = 16'd0;
  endfunction

  function void write_hist(logic [7:0] v);
    hist[wptr] = v;
    wptr       = wptr + 1'b1;
  endfunction

  // Advance the parser by one accepted stream byte and queue its output words
  function void take_stream_byte(lzss_pkg::in_t t);
    logic [7:0]                     b;
    logic [7:0]                     v;
    logic [lzss_pkg::HIST_BITS-1:0] rd;
    lzss_pkg::out_t                 w;
    int                             n;
    b = t.in_byte;
    n_bytes++;
    case (phase)
      PH_COUNT: begin
        groups_left = (b > 8'd1) ? b - 8'd1 : 8'd0;
        grp_pos     = 2'd0;
        phase       = PH_FIRST;
      end
      PH_FIRST, PH_GROUP: begin
        write_hist(b);
        w            = '0;
        w.out_byte_a = b;
        w.out_count  = 3'd1;
        w.out_final  = 1'b1;
        pending_words.push_back(w);
        grp_pos = grp_pos + 2'd1;
        if (phase == PH_FIRST) begin
          if (grp_pos >= 2'd2) begin
            grp_pos = 2'd0;
            phase   = (groups_left != 8'd0) ? PH_GROUP : PH_ADDR_HI;
          end
        end else if (grp_pos >= 2'd3) begin
          grp_pos     = 2'd0;
          groups_left = groups_left - 8'd1;
          if (groups_left == 8'd0) phase = PH_ADDR_HI;
        end
      end
      PH_ADDR_HI: begin
        ref_addr = {b, 8'h00};
        phase    = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        ref_addr[7:0] = b;
        phase         = PH_LEN;
      end
      PH_LEN: begin
        // Copy byte by byte so that an overlapping copy repeats its own output
        n  = (int'(b) + 255) % 256;
        rd = ref_addr[lzss_pkg::HIST_BITS-1:0];
        w  = '0;
        for (int i = 0; i < n; i++) begin
          v = hist[rd];
          write_hist(v);
          rd = rd + 1'b1;
          if (i % 4 == 0) w = '0;
          case (i % 4)
            0: w.out_byte_a = v;
            1: w.out_byte_b = v;
            2: w.out_byte_c = v;
            default: w.out_byte_d = v;
          endcase
          w.out_count = 3'(i % 4 + 1);
          if (i % 4 == 3 || i == n - 1) begin
            w.out_final = (i == n - 1);
            pending_words.push_back(w);
          end
        end
        if (n > 0) n_copies++;
        if (n > max_copy) max_copy = n;
        phase = PH_COUNT;
      end
      default: phase = PH_COUNT;
    endcase
    // Drop an unfinished block on the final stream byte
    if (t.in_last) begin
      if (phase != PH_COUNT) n_dropped++;
      phase       = PH_COUNT;
      groups_left = 8'd0;
      grp_pos     = 2'd0;
    end
  endfunction

  function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ERROR %s: expected %02h, actual %02h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  // Compare one output transaction with the oldest predicted word
  function void check_output(lzss_pkg::out_t got);
    lzss_pkg::out_t exp_w;
    if (pending_words.size() == 0) begin
      $display("%0t ERROR unexpected output word: expected none, actual %h", $time, got);
      n_errors++;
      return;
    end
    exp_w = pending_words.pop_front();
    n_words++;
    compare_field("out_byte_a", exp_w.out_byte_a, got.out_byte_a);
    compare_field("out_byte_b", exp_w.out_byte_b, got.out_byte_b);
    compare_field("out_byte_c", exp_w.out_byte_c, got.out_byte_c);
    compare_field("out_byte_d", exp_w.out_byte_d, got.out_byte_d);
    compare_field("out_count", 8'(exp_w.out_count), 8'(got.out_count));
    compare_field("out_final", 8'(exp_w.out_final), 8'(got.out_final));
  endfunction

  function int pending();
    return pending_words.size();
  endfunction
endclass

module tb_lzss_block_decompressor;

  localparam int ITEM_TARGET = 430;
  localparam int QUIET_FROM  = 360;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 700;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int NO_CUT      = -1;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  lzss_pkg::in_t   in_data   = '0;
  logic            out_ready = 1'b0;
  logic            in_ready;
  logic            out_valid;
  lzss_pkg::out_t  out_data;

  lzss_output_scoreboard sb;
  int cycles       = 0;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  bit hold_req     = 1'b0;

  lzss_block_decompressor u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d output words outstanding", $time, sb.pending());
      $display("tb_lzss_block_decompressor NOT OK");
      $finish;
    end
  end

  // Check every output transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_output(out_data);
  end

  // Receiver: random stall bursts and one long hold
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Offer one stream byte, hold it until accepted, then predict its output
  task automatic send_byte(input logic [7:0] b, input logic last);
    lzss_pkg::in_t item;
    item.in_byte = b;
    item.in_last = last;
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_stream_byte(item);
  endtask

  // Send one block with random literals; near means where is a distance back
  // from the write pointer at the back-reference. cut_at marks in_last.
  task automatic send_block(input logic [7:0] cnt, input bit near, input logic [15:0] where,
                            input logic [7:0] len, input int cut_at);
    logic [7:0]  blk [$];
    logic [15:0] addr;
    int          n_lit;
    n_lit = (cnt > 8'd1) ? 3 * int'(cnt) - 1 : 2;
    addr  = near ? 16'(sb.wptr + n_lit - where) : where;
    blk.push_back(cnt);
    repeat (n_lit) blk.push_back(8'($urandom));
    blk.push_back(addr[15:8]);
    blk.push_back(addr[7:0]);
    blk.push_back(len);
    foreach (blk[i]) begin
      send_byte(blk[i], i == cut_at);
      if (i == cut_at) break;
    end
  endtask

  task automatic random_block();
    logic [7:0]  cnt;
    logic [7:0]  len;
    logic [15:0] where;
    bit          near;
    int          total;
    int          r;
    int          cut;
    cnt   = ($urandom_range(99) < 5) ? 8'($urandom_range(10, 30)) : 8'($urandom_range(0, 4));
    r     = $urandom_range(99);
    len   = (r < 15) ? 8'($urandom_range(0, 1)) :
            (r < 60) ? 8'($urandom_range(2, 24)) : 8'($urandom);
    near  = $urandom_range(99) < 70;
    where = near ? 16'($urandom_range(1, 40)) : 16'($urandom);
    total = (cnt > 8'd1) ? 3 * int'(cnt) + 3 : 6;
    r     = $urandom_range(99);
    cut   = (r < 8) ? $urandom_range(0, total - 2) : (r < 14) ? total - 1 : NO_CUT;
    send_block(cnt, near, where, len, cut);
  endtask

  initial begin
    bit hold_done  = 1'b0;
    bit pause_done = 1'b0;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Zero count byte, extreme literals, length byte of one copies nothing
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    // Two groups, then a copy overlapping its own output
    send_block(8'd2, 1'b1, 16'd3, 8'd11, NO_CUT);
    // Length byte of zero from the top of history, wrapping, in_last on it
    send_block(8'd1, 1'b0, 16'hFFFE, 8'd0, 5);
    // Largest count byte, block cut short by in_last
    send_block(8'hFF, 1'b0, 16'h0000, 8'd2, 3);

    // Random blocks with varying stall rates
    while (sb.n_bytes < ITEM_TARGET) begin
      if (!hold_done && sb.n_bytes >= 150) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (!pause_done && sb.n_bytes >= 260) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      if (sb.n_bytes >= QUIET_FROM) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 25 * $urandom_range(0, 2);
        out_idle_pct = 25 * $urandom_range(0, 2);
      end
      random_block();
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray output words
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d stream bytes and %0d output words, %0d copies (longest %0d bytes),",
             sb.n_bytes, sb.n_words, sb.n_copies, sb.max_copy);
    $display("%0d blocks cut short by in_last, one long output hold and one full drain.",
             sb.n_dropped);
    if (sb.n_errors == 0) begin
      $display("tb_lzss_block_decompressor OK");
    end else begin
      $display("tb_lzss_block_decompressor NOT OK");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/lzss_pkg.sv
sv/lzss_front.sv
sv/lzss_cmd_fifo.sv
sv/lzss_back.sv
sv/lzss_block_decompressor.sv
test/tb_lzss_block_decompressor.sv
